/* hw/rtl/hsvrgb_pkg.sv */
// Shared types and constants for the HSV to RGB converter pipeline.
// Holds the hue sector decode, the sector code, and the divider stage controls.
// Used by hsvrgb_cdiv and hsv_to_rgb_converter; depends on nothing.
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned HUE_W          = 9;
    localparam int unsigned FIELD_W        = 8;
    localparam int unsigned REM_W          = 6;
    localparam int unsigned DEG_PER_SECTOR = 60;
    localparam int unsigned HUE_LIMIT      = 360;

    typedef enum logic [2:0] {
        SECT_0,
        SECT_1,
        SECT_2,
        SECT_3,
        SECT_4,
        SECT_5
    } sector_t;

    typedef struct packed {
        logic             black;
        sector_t          sector;
        logic [REM_W-1:0] rem;
    } hue_split_t;

    typedef struct packed {
        logic est_en;
        logic prod_en;
    } div_ctl_t;

    function automatic hue_split_t split_hue(input logic [HUE_W-1:0] hue);
        hue_split_t       res;
        logic [HUE_W-1:0] base;
        res.black  = 1'b0;
        res.sector = SECT_0;
        base       = '0;
        if (hue >= HUE_W'(HUE_LIMIT))
        begin
            res.black = 1'b1;
            base      = hue;
        end
        else if (hue >= HUE_W'(5 * DEG_PER_SECTOR))
        begin
            res.sector = SECT_5;
            base       = HUE_W'(5 * DEG_PER_SECTOR);
        end
        else if (hue >= HUE_W'(4 * DEG_PER_SECTOR))
        begin
            res.sector = SECT_4;
            base       = HUE_W'(4 * DEG_PER_SECTOR);
        end
        else if (hue >= HUE_W'(3 * DEG_PER_SECTOR))
        begin
            res.sector = SECT_3;
            base       = HUE_W'(3 * DEG_PER_SECTOR);
        end
        else if (hue >= HUE_W'(2 * DEG_PER_SECTOR))
        begin
            res.sector = SECT_2;
            base       = HUE_W'(2 * DEG_PER_SECTOR);
        end
        else if (hue >= HUE_W'(DEG_PER_SECTOR))
        begin
            res.sector = SECT_1;
            base       = HUE_W'(DEG_PER_SECTOR);
        end
        res.rem = REM_W'(hue - base);
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsvrgb_cdiv.sv */
// Two-stage floor division of an unsigned word by a fixed divisor.
// Reciprocal estimate, then one multiply-back and a single correction step.
// Depends on hsvrgb_pkg for the stage control struct.
`default_nettype none

module hsvrgb_cdiv #(
    parameter int unsigned XW      = 16,
    parameter int unsigned QW      = 8,
    parameter int unsigned DIVISOR = 255
) (
    input  wire logic                 clk,
    input  wire hsvrgb_pkg::div_ctl_t ctl,
    input  wire logic [XW-1:0]        dividend,
    output logic      [QW-1:0]        quotient
);

    localparam longint unsigned RECIP = (64'd1 << XW) / DIVISOR;
    localparam int unsigned     RW    = $clog2(RECIP + 1);
    localparam int unsigned     DW    = $clog2(DIVISOR + 1);

    logic [XW+RW-1:0] est_prod;
    logic [XW+RW-1:0] est_shift;
    logic [QW-1:0]    est_next;
    logic [XW-1:0]    x_reg;
    logic [QW-1:0]    est_reg;

    logic [QW+DW-1:0] prod_next;
    logic [QW+DW-1:0] prod_reg;
    logic [XW-1:0]    x2_reg;
    logic [QW-1:0]    est2_reg;
    logic [XW-1:0]    rem_val;

    assign est_prod  = dividend * RW'(RECIP);
    assign est_shift = est_prod >> XW;
    assign est_next  = QW'(est_shift);

    always_ff @(posedge clk)
    begin
        if (ctl.est_en)
        begin
            x_reg   <= dividend;
            est_reg <= est_next;
        end
    end

    assign prod_next = est_reg * DW'(DIVISOR);

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            prod_reg <= prod_next;
            x2_reg   <= x_reg;
            est2_reg <= est_reg;
        end
    end

    // estimate is exact or one low; bump it when the remainder reaches the divisor
    assign rem_val  = x2_reg - XW'(prod_reg);
    assign quotient = est2_reg + QW'(rem_val >= XW'(DIVISOR));

endmodule

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter top level: six-stage pipeline with valid/stall channels.
// Instantiates hsvrgb_cdiv three times (p, q and t terms); uses hsvrgb_pkg.
//
// Usage:
//   Input channel: in_valid, in_stall, and the word hue, saturation, brightness.
//   Output channel: out_valid, out_stall, and the word red, green, blue.
//   A word moves at a rising edge where valid is high and stall is low.
//   One output word per input word, in order.
// Throughput: one word per cycle while out_stall is low; the limit is the stages of the
//   pipeline (hue decode, partial products, numerators, reciprocal estimate,
//   multiply-back, correction and sector routing).
// Stall: a stalled output holds its word; bubbles inside the pipeline still
//   close up, and in_stall rises only when all six stages hold words.
// Reset: rst_n clears every stage valid bit; words in flight are dropped.
// Hue of 360 and above gives black. Saturation and brightness use the low
//   CHANNEL_BITS bits (at most FIELD_W), where all ones means full scale.
`default_nettype none

module hsv_to_rgb_converter #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]          hue,
    input  wire logic [hsvrgb_pkg::FIELD_W-1:0]        saturation,
    input  wire logic [hsvrgb_pkg::FIELD_W-1:0]        brightness,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic      [hsvrgb_pkg::FIELD_W-1:0]        red,
    output logic      [hsvrgb_pkg::FIELD_W-1:0]        green,
    output logic      [hsvrgb_pkg::FIELD_W-1:0]        blue
);

    localparam int unsigned STAGES = 6;
    localparam int unsigned SW     = (CHANNEL_BITS < hsvrgb_pkg::FIELD_W) ?
                                     CHANNEL_BITS : hsvrgb_pkg::FIELD_W;
    localparam int unsigned FS     = (1 << CHANNEL_BITS) - 1;
    localparam int unsigned SPAN   = hsvrgb_pkg::DEG_PER_SECTOR * FS;
    localparam int unsigned SPW    = $clog2(SPAN + 1);
    localparam int unsigned REM_W  = hsvrgb_pkg::REM_W;
    localparam int unsigned XPW    = SW + CHANNEL_BITS;
    localparam int unsigned XQW    = SW + SPW;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;

    // stage 0: hue decode
    hsvrgb_pkg::hue_split_t split_next;
    hsvrgb_pkg::hue_split_t split0_reg;
    logic [SW-1:0]          s0_reg;
    logic [SW-1:0]          v0_reg;

    // stage 1: saturation partial products
    logic [REM_W-1:0]        rinv_next;
    logic [CHANNEL_BITS-1:0] sfs_next;
    logic [SW+REM_W-1:0]     sq_next;
    logic [SW+REM_W-1:0]     st_next;
    logic [CHANNEL_BITS-1:0] sfs1_reg;
    logic [SW+REM_W-1:0]     sq1_reg;
    logic [SW+REM_W-1:0]     st1_reg;
    hsvrgb_pkg::hue_split_t  split1_reg;
    logic [SW-1:0]           v1_reg;

    // stage 2: numerators
    logic [SPW-1:0]         numq_next;
    logic [SPW-1:0]         numt_next;
    logic [XPW-1:0]         xp_next;
    logic [XQW-1:0]         xq_next;
    logic [XQW-1:0]         xt_next;
    logic [XPW-1:0]         xp2_reg;
    logic [XQW-1:0]         xq2_reg;
    logic [XQW-1:0]         xt2_reg;
    hsvrgb_pkg::hue_split_t split2_reg;
    logic [SW-1:0]          v2_reg;

    // stages 3 and 4: dividers, with side data carried alongside
    hsvrgb_pkg::div_ctl_t   div_ctl;
    logic [SW-1:0]          p_quot;
    logic [SW-1:0]          q_quot;
    logic [SW-1:0]          t_quot;
    hsvrgb_pkg::hue_split_t split3_reg;
    logic [SW-1:0]          v3_reg;
    hsvrgb_pkg::hue_split_t split4_reg;
    logic [SW-1:0]          v4_reg;

    // stage 5: sector routing and output word
    logic [SW-1:0]                      r_sel;
    logic [SW-1:0]                      g_sel;
    logic [SW-1:0]                      b_sel;
    logic [hsvrgb_pkg::FIELD_W-1:0]     red_reg;
    logic [hsvrgb_pkg::FIELD_W-1:0]     green_reg;
    logic [hsvrgb_pkg::FIELD_W-1:0]     blue_reg;

    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign split_next = hsvrgb_pkg::split_hue(hue);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            split0_reg <= split_next;
            s0_reg     <= saturation[SW-1:0];
            v0_reg     <= brightness[SW-1:0];
        end
    end

    assign rinv_next = REM_W'(hsvrgb_pkg::DEG_PER_SECTOR) - split0_reg.rem;
    assign sfs_next  = CHANNEL_BITS'(FS) - CHANNEL_BITS'(s0_reg);
    assign sq_next   = s0_reg * split0_reg.rem;
    assign st_next   = s0_reg * rinv_next;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sfs1_reg   <= sfs_next;
            sq1_reg    <= sq_next;
            st1_reg    <= st_next;
            split1_reg <= split0_reg;
            v1_reg     <= v0_reg;
        end
    end

    assign numq_next = SPW'(SPAN) - SPW'(sq1_reg);
    assign numt_next = SPW'(SPAN) - SPW'(st1_reg);
    assign xp_next   = v1_reg * sfs1_reg;
    assign xq_next   = v1_reg * numq_next;
    assign xt_next   = v1_reg * numt_next;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            xp2_reg    <= xp_next;
            xq2_reg    <= xq_next;
            xt2_reg    <= xt_next;
            split2_reg <= split1_reg;
            v2_reg     <= v1_reg;
        end
    end

    assign div_ctl.est_en  = adv[3];
    assign div_ctl.prod_en = adv[4];

    hsvrgb_cdiv #(
        .XW      (XPW),
        .QW      (SW),
        .DIVISOR (FS)
    ) u_div_p (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (xp2_reg),
        .quotient (p_quot)
    );

    hsvrgb_cdiv #(
        .XW      (XQW),
        .QW      (SW),
        .DIVISOR (SPAN)
    ) u_div_q (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (xq2_reg),
        .quotient (q_quot)
    );

    hsvrgb_cdiv #(
        .XW      (XQW),
        .QW      (SW),
        .DIVISOR (SPAN)
    ) u_div_t (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (xt2_reg),
        .quotient (t_quot)
    );

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            split3_reg <= split2_reg;
            v3_reg     <= v2_reg;
        end
        if (adv[4])
        begin
            split4_reg <= split3_reg;
            v4_reg     <= v3_reg;
        end
    end

    always_comb
    begin
        case (split4_reg.sector)
            hsvrgb_pkg::SECT_0:
            begin
                r_sel = v4_reg;
                g_sel = t_quot;
                b_sel = p_quot;
            end
            hsvrgb_pkg::SECT_1:
            begin
                r_sel = q_quot;
                g_sel = v4_reg;
                b_sel = p_quot;
            end
            hsvrgb_pkg::SECT_2:
            begin
                r_sel = p_quot;
                g_sel = v4_reg;
                b_sel = t_quot;
            end
            hsvrgb_pkg::SECT_3:
            begin
                r_sel = p_quot;
                g_sel = q_quot;
                b_sel = v4_reg;
            end
            hsvrgb_pkg::SECT_4:
            begin
                r_sel = t_quot;
                g_sel = p_quot;
                b_sel = v4_reg;
            end
            default:
            begin
                r_sel = v4_reg;
                g_sel = p_quot;
                b_sel = q_quot;
            end
        endcase
        if (split4_reg.black)
        begin
            r_sel = '0;
            g_sel = '0;
            b_sel = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            red_reg   <= hsvrgb_pkg::FIELD_W'(r_sel);
            green_reg <= hsvrgb_pkg::FIELD_W'(g_sel);
            blue_reg  <= hsvrgb_pkg::FIELD_W'(b_sel);
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
    else $error("input stalled while a pipeline stage is empty");

    a_last_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && adv[5] |=> out_valid)
    else $error("word lost between divider and output stage");

    a_terms_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (p_quot <= v4_reg) && (q_quot <= v4_reg) && (t_quot <= v4_reg))
    else $error("divider result exceeds brightness");

endmodule

`default_nettype wire
